// ----- rtl/core/bdc_pkg.sv -----
// Package: payload structs, config struct, register indexes and reset values for the dimmer.
`timescale 1ns / 1ps
package bdc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SAVED_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LOCKOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_HOLD = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG_HOLD = 2'd3;

  // Reset values
  localparam logic [7:0] SavedLevelRst = 8'd255;
  localparam logic [15:0] PressLockoutRst = 16'd200;
  localparam logic [15:0] MinHoldRst = 16'd100;
  localparam logic [15:0] LongHoldRst = 16'd2000;
  localparam logic [7:0] BrightRst = 8'd255;
  localparam logic [7:0] BrightMax = 8'd255;
  localparam logic KeyReleased = 1'b1;

  typedef struct packed {
    logic        key_level;
    logic [31:0] now_ms;
  } bdc_in_t;

  typedef struct packed {
    logic [7:0] level;
    logic       refresh;
    logic       adjusting;
  } bdc_out_t;

  typedef struct packed {
    logic [7:0]  saved_level;
    logic [15:0] press_lockout_ms;
    logic [15:0] min_hold_ms;
    logic [15:0] long_hold_ms;
  } bdc_cfg_t;

endpackage

// ----- rtl/core/bdc_cfg_regs.sv -----
// Configuration register file for the dimmer.
`timescale 1ns / 1ps
module bdc_cfg_regs
  import bdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output bdc_cfg_t            cfg_o
);

  bdc_cfg_t cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.saved_level <= SavedLevelRst;
      cfg_q.press_lockout_ms <= PressLockoutRst;
      cfg_q.min_hold_ms <= MinHoldRst;
      cfg_q.long_hold_ms <= LongHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAVED_LEVEL:   cfg_q.saved_level <= cfg_data_i[7:0];
        CFG_PRESS_LOCKOUT: cfg_q.press_lockout_ms <= cfg_data_i;
        CFG_MIN_HOLD:      cfg_q.min_hold_ms <= cfg_data_i;
        CFG_LONG_HOLD:     cfg_q.long_hold_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/bdc_step.sv -----
// Key state, hold timing and brightness update for one poll.
`timescale 1ns / 1ps
module bdc_step
  import bdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  bdc_in_t  item_i,
  input  bdc_cfg_t cfg_i,
  output bdc_out_t res_o
);

  logic        last_q, last_d;
  logic [31:0] start_q, start_d;
  logic [7:0]  bright_q, bright_d;
  logic        adj_q, adj_d;
  logic        ramp_q, ramp_d;

  logic        key;
  logic [31:0] since_start;
  logic        start_now;
  logic [31:0] held;
  logic        release_act;
  logic        refresh;

  assign key = item_i.key_level;

  // Time since the last press start and the press-edge restart
  assign since_start = item_i.now_ms - start_q;
  assign start_now = !key && last_q && (since_start > {16'd0, cfg_i.press_lockout_ms});
  assign start_d = start_now ? item_i.now_ms : start_q;
  assign held = start_now ? 32'd0 : since_start;
  assign release_act = key && !last_q && (held > {16'd0, cfg_i.min_hold_ms});
  assign last_d = key;

  // Release action, then one ramp step
  always_comb begin
    bright_d = bright_q;
    adj_d = adj_q;
    ramp_d = ramp_q;
    refresh = 1'b0;
    if (release_act) begin
      if (adj_q) begin
        adj_d = 1'b0;
      end else if (held < {16'd0, cfg_i.long_hold_ms}) begin
        bright_d = (bright_q == 8'd0) ? cfg_i.saved_level : 8'd0;
        refresh = 1'b1;
      end else begin
        adj_d = 1'b1;
        ramp_d = 1'b1;
      end
    end
    if (ramp_d) begin
      if (key) begin
        bright_d = (bright_d == BrightMax) ? 8'd1 : bright_d + 8'd1;
        refresh = 1'b1;
      end else begin
        ramp_d = 1'b0;
      end
    end
  end

  assign res_o.level = bright_d;
  assign res_o.refresh = refresh;
  assign res_o.adjusting = adj_d;

  // Advance the state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= KeyReleased;
      start_q <= 32'd0;
      bright_q <= BrightRst;
      adj_q <= 1'b0;
      ramp_q <= 1'b0;
    end else if (fire_i) begin
      last_q <= last_d;
      start_q <= start_d;
      bright_q <= bright_d;
      adj_q <= adj_d;
      ramp_q <= ramp_d;
    end
  end

`ifndef SYNTHESIS
  a_ramp_in_adjust: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_q |-> adj_q) else $error("ramp running outside adjust mode");
  a_press_stops_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !key) |=> !ramp_q) else $error("ramp survived a pressed poll");
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(bright_q) && $stable(start_q) && $stable(adj_q)))
    else $error("state changed without an item");
`endif

endmodule

// ----- rtl/core/button_dimmer_control.sv -----
// Top level of the single-key dimmer: input register, step logic, result register.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o   in_item_i  (bdc_in_t)
//   out      source     out_valid_o / out_stall_i out_item_o (bdc_out_t)
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per clock sustained while out_stall_i is low; an accepted item enters the input
// register, then the result register, where it is valid. The input register feeds the step
// logic, which updates the key state and loads the result register together. Reset restores
// state, configuration and valid bits at once; the payload registers carry no reset.
// A stalled result holds; the input register then fills and in_stall_o rises.
`timescale 1ns / 1ps
module button_dimmer_control
  import bdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bdc_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bdc_out_t            out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  bdc_cfg_t cfg;
  bdc_out_t res;
  bdc_in_t  s1_item_q;
  logic     s1_valid_q;
  bdc_out_t out_item_q;
  logic     out_valid_q;
  logic     out_free;
  logic     fire;
  logic     in_take;

  bdc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bdc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Handshake: the input register moves on when the result register can take it
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q)) else $error("stall without a held item");
  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("item lost between stages");
  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(s1_item_q))) else $error("held item dropped");
`endif

endmodule
